@@ hdl/tdss_pkg.sv @@
package tdss_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREPARE_MINUTES      = 3'd0,
    CFG_CYCLE_TOTAL          = 3'd1,
    CFG_CYCLE_MINUTES        = 3'd2,
    CFG_RUN_MINUTES          = 3'd3,
    CFG_HEATER_SECONDS       = 3'd4,
    CFG_FAN_RELOAD_SECONDS   = 3'd5,
    CFG_LED_LEAD_SECONDS     = 3'd6,
    CFG_HEATER_FIRST_MINUTES = 3'd7
  } cfg_idx_e;

  localparam logic [9:0]  RstPrepareMinutes     = 10'd30;
  localparam logic [7:0]  RstCycleTotal         = 8'd12;
  localparam logic [9:0]  RstCycleMinutes       = 10'd60;
  localparam logic [9:0]  RstRunMinutes         = 10'd10;
  localparam logic [15:0] RstHeaterSeconds      = 16'd300;
  localparam logic [15:0] RstFanReloadSeconds   = 16'd300;
  localparam logic [15:0] RstLedLeadSeconds     = 16'd60;
  localparam logic [9:0]  RstHeaterFirstMinutes = 10'd5;

  localparam logic HeaterFirstState = 1'b1;
  localparam logic ShortFirstCycle  = 1'b1;

  localparam logic [5:0]  SecsPerMin = 6'd60;
  // floor(x * Div60Recip / 2^Div60Shift) equals x / 60 for every x below 2^16.
  localparam logic [15:0] Div60Recip = 16'd34953;
  localparam int unsigned Div60Shift = 21;
  localparam logic [7:0]  HoursMax   = 8'd255;
  // Any sum at or above this gives a quotient of at least 255.
  localparam logic [18:0] HoursSatSum = 19'd15300;

  typedef struct packed {
    logic [9:0]  prepare_minutes;
    logic [7:0]  cycle_total;
    logic [9:0]  cycle_minutes;
    logic [9:0]  run_minutes;
    logic [15:0] heater_seconds;
    logic [15:0] fan_reload_seconds;
    logic [15:0] led_lead_seconds;
    logic [9:0]  heater_first_minutes;
  } cfg_t;

  typedef struct packed {
    logic        fan_on;
    logic        heater_on;
    logic        led_on;
    logic        power_off_request;
    logic        waiting;
    logic [7:0]  cycles_left;
    logic [15:0] cycle_left;
  } snap_t;

  typedef struct packed {
    logic       fan_on;
    logic       heater_on;
    logic       led_on;
    logic       power_off_request;
    logic [7:0] hours_left;
  } result_t;

endpackage

@@ hdl/tdss_if.sv @@
interface tdss_req_if;
  logic valid;
  logic ready;
  logic start_req;
  logic tick_level;
  logic hold;

  modport source (output valid, output start_req, output tick_level, output hold,
                  input ready);
  modport sink (input valid, input start_req, input tick_level, input hold,
                output ready);
endinterface

interface tdss_rsp_if;
  logic       valid;
  logic       ready;
  logic       fan_on;
  logic       heater_on;
  logic       led_on;
  logic       power_off_request;
  logic [7:0] hours_left;

  modport source (output valid, output fan_on, output heater_on, output led_on,
                  output power_off_request, output hours_left, input ready);
  modport sink (input valid, input fan_on, input heater_on, input led_on,
                input power_off_request, input hours_left, output ready);
endinterface

@@ hdl/tdss_cfg.sv @@
module tdss_cfg import tdss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prepare_minutes      <= RstPrepareMinutes;
      cfg_q.cycle_total          <= RstCycleTotal;
      cfg_q.cycle_minutes        <= RstCycleMinutes;
      cfg_q.run_minutes          <= RstRunMinutes;
      cfg_q.heater_seconds       <= RstHeaterSeconds;
      cfg_q.fan_reload_seconds   <= RstFanReloadSeconds;
      cfg_q.led_lead_seconds     <= RstLedLeadSeconds;
      cfg_q.heater_first_minutes <= RstHeaterFirstMinutes;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PREPARE_MINUTES:      cfg_q.prepare_minutes      <= cfg_data_i[9:0];
        CFG_CYCLE_TOTAL:          cfg_q.cycle_total          <= cfg_data_i[7:0];
        CFG_CYCLE_MINUTES:        cfg_q.cycle_minutes        <= cfg_data_i[9:0];
        CFG_RUN_MINUTES:          cfg_q.run_minutes          <= cfg_data_i[9:0];
        CFG_HEATER_SECONDS:       cfg_q.heater_seconds       <= cfg_data_i;
        CFG_FAN_RELOAD_SECONDS:   cfg_q.fan_reload_seconds   <= cfg_data_i;
        CFG_LED_LEAD_SECONDS:     cfg_q.led_lead_seconds     <= cfg_data_i;
        CFG_HEATER_FIRST_MINUTES: cfg_q.heater_first_minutes <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/tdss_core.sv @@
module tdss_core import tdss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  logic  start_req_i,
  input  logic  tick_level_i,
  input  logic  hold_i,
  input  cfg_t  cfg_i,
  output snap_t snap_o
);

  typedef struct packed {
    logic        waiting;
    logic        saving;
    logic        reload_pending;
    logic        fan_flag;
    logic        heater_flag;
    logic        led_flag;
    logic        last_tick;
    logic [7:0]  cycles_left;
    logic [15:0] prepare_left;
    logic [15:0] cycle_left;
    logic [15:0] idle_left;
    logic [15:0] run_left;
    logic [15:0] heater_left;
    logic [15:0] fan_left;
  } core_state_t;

  function automatic logic [15:0] mins16(input logic [15:0] m);
    logic [21:0] p;
    p = 22'(m) * 22'(SecsPerMin);
    return p[15:0];
  endfunction

  function automatic logic [15:0] dec16(input logic [15:0] v);
    return (v != 16'd0) ? v - 16'd1 : 16'd0;
  endfunction

  core_state_t st_q, st_d;
  snap_t       snap_q, snap_d;
  logic        power_off;
  logic [15:0] prep_mins, cyc_mins, run_mins, first_mins;

  assign prep_mins  = 16'(cfg_i.prepare_minutes);
  assign cyc_mins   = 16'(cfg_i.cycle_minutes);
  assign run_mins   = 16'(cfg_i.run_minutes);
  assign first_mins = 16'(cfg_i.heater_first_minutes);

  always_comb begin
    st_d      = st_q;
    power_off = 1'b0;
    if (start_req_i) begin
      st_d.prepare_left = mins16(prep_mins);
      st_d.cycles_left  = cfg_i.cycle_total;
      st_d.cycle_left   = 16'd0;
      st_d.idle_left    = 16'd0;
      st_d.waiting      = 1'b1;
    end
    if (st_d.reload_pending) begin
      st_d.reload_pending = 1'b0;
      if (ShortFirstCycle && cfg_i.cycle_total != 8'd0 &&
          st_d.cycles_left == cfg_i.cycle_total - 8'd1) begin
        st_d.cycle_left = mins16(cyc_mins - prep_mins);
        st_d.idle_left  = mins16(cyc_mins - prep_mins - run_mins);
      end else begin
        st_d.cycle_left = mins16(cyc_mins);
        st_d.idle_left  = mins16(cyc_mins - run_mins);
      end
      st_d.saving      = 1'b1;
      st_d.fan_flag    = 1'b0;
      st_d.led_flag    = 1'b0;
      st_d.heater_flag = 1'b0;
    end
    if (!hold_i) begin
      if (tick_level_i != st_d.last_tick) begin
        st_d.last_tick    = tick_level_i;
        st_d.prepare_left = dec16(st_d.prepare_left);
        st_d.cycle_left   = dec16(st_d.cycle_left);
        st_d.run_left     = dec16(st_d.run_left);
        st_d.idle_left    = dec16(st_d.idle_left);
        st_d.heater_left  = dec16(st_d.heater_left);
        st_d.fan_left     = dec16(st_d.fan_left);
      end
      if (st_d.waiting) begin
        st_d.fan_flag = 1'b1;
        st_d.led_flag = 1'b1;
        if (st_d.prepare_left >= mins16(prep_mins - first_mins)) begin
          st_d.heater_flag = HeaterFirstState;
        end else begin
          st_d.heater_flag = !HeaterFirstState;
        end
        if (st_d.prepare_left == 16'd0) begin
          st_d.waiting    = 1'b0;
          st_d.cycle_left = 16'd0;
          st_d.idle_left  = 16'd0;
        end
      end else if (st_d.cycle_left == 16'd0) begin
        st_d.reload_pending = 1'b1;
        if (st_d.cycles_left != 8'd0) begin
          st_d.cycles_left = st_d.cycles_left - 8'd1;
        end else begin
          power_off = 1'b1;
        end
      end else begin
        if (st_d.saving && st_d.idle_left == 16'd0) begin
          st_d.saving      = 1'b0;
          st_d.fan_flag    = 1'b1;
          st_d.heater_flag = 1'b1;
          st_d.led_flag    = 1'b0;
          st_d.run_left    = mins16(run_mins);
          st_d.heater_left = cfg_i.heater_seconds;
        end
        if (st_d.fan_flag) begin
          if (cfg_i.led_lead_seconds > st_d.run_left) begin
            st_d.led_flag = 1'b1;
          end
          if (st_d.heater_flag) begin
            if (st_d.heater_left == 16'd0) begin
              st_d.heater_flag = 1'b0;
              st_d.fan_left    = cfg_i.fan_reload_seconds;
            end else if (st_d.fan_left == 16'd0) begin
              st_d.heater_flag = 1'b1;
              st_d.fan_left    = cfg_i.heater_seconds;
            end
          end
        end
      end
    end
    snap_d.fan_on            = !hold_i && st_d.fan_flag;
    snap_d.heater_on         = !hold_i && st_d.heater_flag;
    snap_d.led_on            = !hold_i && st_d.led_flag;
    snap_d.power_off_request = power_off;
    snap_d.waiting           = st_d.waiting;
    snap_d.cycles_left       = st_d.cycles_left;
    snap_d.cycle_left        = st_d.cycle_left;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      snap_q <= snap_d;
    end
  end

  assign snap_o = snap_q;

endmodule

@@ hdl/tdss_hours.sv @@
module tdss_hours import tdss_pkg::*; (
  input  logic       clk_i,
  input  logic       mul_en_i,
  input  logic       fin_en_i,
  input  snap_t      snap_i,
  input  logic [9:0] cycle_minutes_i,
  output result_t    result_o
);

  logic [17:0] prod_q;
  logic [10:0] cdiv_q;
  logic        waiting_q, nz_q;
  logic [3:0]  flags_q;
  logic [31:0] cdiv_full;
  logic [18:0] sum;
  logic [29:0] qdiv_full;
  logic [7:0]  qsat;
  logic [7:0]  hours;
  result_t     result_q;

  assign cdiv_full = 32'(snap_i.cycle_left) * 32'(Div60Recip);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q    <= 18'(snap_i.cycles_left) * 18'(cycle_minutes_i);
      cdiv_q    <= cdiv_full[Div60Shift +: 11];
      waiting_q <= snap_i.waiting;
      nz_q      <= snap_i.cycles_left != 8'd0;
      flags_q   <= {snap_i.fan_on, snap_i.heater_on, snap_i.led_on,
                    snap_i.power_off_request};
    end
  end

  always_comb begin
    sum       = 19'(prod_q) + (waiting_q ? 19'd0 : 19'(cdiv_q));
    qdiv_full = 30'(sum[13:0]) * 30'(Div60Recip);
    qsat      = (sum >= HoursSatSum) ? HoursMax : qdiv_full[Div60Shift +: 8];
    if (waiting_q) begin
      hours = qsat;
    end else if (nz_q) begin
      hours = (qsat == HoursMax) ? HoursMax : qsat + 8'd1;
    end else begin
      hours = 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en_i) begin
      result_q.fan_on            <= flags_q[3];
      result_q.heater_on         <= flags_q[2];
      result_q.led_on            <= flags_q[1];
      result_q.power_off_request <= flags_q[0];
      result_q.hours_left        <= hours;
    end
  end

  assign result_o = result_q;

endmodule

@@ hdl/timed_dry_storage_sequencer.sv @@
// A request accepted at the input passes through the four pipeline registers (input, sequencer,
// hours product, result) in order. Throughput: one request per cycle while the result side
// takes one per cycle.
// Reset clears the sequencing state and pipeline valids and loads the register defaults.
module timed_dry_storage_sequencer import tdss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tdss_req_if.sink            req_i,
  tdss_rsp_if.source          rsp_o
);

  cfg_t    cfg;
  snap_t   snap;
  result_t result;

  logic in_v_q, core_v_q, mul_v_q, out_v_q;
  logic out_rdy, mul_rdy, core_rdy, in_rdy;
  logic start_q, tick_q, hold_q;

  assign out_rdy  = !out_v_q || rsp_o.ready;
  assign mul_rdy  = !mul_v_q || out_rdy;
  assign core_rdy = !core_v_q || mul_rdy;
  assign in_rdy   = !in_v_q || core_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      core_v_q <= 1'b0;
      mul_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (in_rdy)   in_v_q   <= req_i.valid;
      if (core_rdy) core_v_q <= in_v_q;
      if (mul_rdy)  mul_v_q  <= core_v_q;
      if (out_rdy)  out_v_q  <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && req_i.valid) begin
      start_q <= req_i.start_req;
      tick_q  <= req_i.tick_level;
      hold_q  <= req_i.hold;
    end
  end

  tdss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tdss_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_v_q && core_rdy),
    .start_req_i  (start_q),
    .tick_level_i (tick_q),
    .hold_i       (hold_q),
    .cfg_i        (cfg),
    .snap_o       (snap)
  );

  tdss_hours u_hours (
    .clk_i           (clk_i),
    .mul_en_i        (core_v_q && mul_rdy),
    .fin_en_i        (mul_v_q && out_rdy),
    .snap_i          (snap),
    .cycle_minutes_i (cfg.cycle_minutes),
    .result_o        (result)
  );

  assign req_i.ready             = in_rdy;
  assign rsp_o.valid             = out_v_q;
  assign rsp_o.fan_on            = result.fan_on;
  assign rsp_o.heater_on         = result.heater_on;
  assign rsp_o.led_on            = result.led_on;
  assign rsp_o.power_off_request = result.power_off_request;
  assign rsp_o.hours_left        = result.hours_left;

endmodule

@@ hdl/tdss_checker.sv @@
module tdss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_fan_on_i,
  input logic       rsp_heater_on_i,
  input logic       rsp_led_on_i,
  input logic       rsp_power_off_request_i,
  input logic [7:0] rsp_hours_left_i
);

  logic [2:0] pend_q;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else if (req_fire && !rsp_fire) begin
      pend_q <= pend_q + 3'd1;
    end else if (rsp_fire && !req_fire) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({rsp_fan_on_i, rsp_heater_on_i, rsp_led_on_i,
               rsp_power_off_request_i, rsp_hours_left_i}))
    else $error("response changed while stalled");

  a_power_off_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_power_off_request_i |-> rsp_hours_left_i == 8'd1)
    else $error("power-off request without one hour left");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 3'd0)
    else $error("response without an outstanding request");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request side stalled while result side is empty");

endmodule

bind timed_dry_storage_sequencer tdss_checker u_tdss_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .req_valid_i             (req_i.valid),
  .req_ready_i             (req_i.ready),
  .rsp_valid_i             (rsp_o.valid),
  .rsp_ready_i             (rsp_o.ready),
  .rsp_fan_on_i            (rsp_o.fan_on),
  .rsp_heater_on_i         (rsp_o.heater_on),
  .rsp_led_on_i            (rsp_o.led_on),
  .rsp_power_off_request_i (rsp_o.power_off_request),
  .rsp_hours_left_i        (rsp_o.hours_left)
);
